FILE: rtl/tgd_pkg.sv
// tgd_pkg: shared types and constants for the tga uncompressed decoder
// no dependencies; used by every module in rtl

package tgd_pkg;

  localparam int HDR_SIZE_W  = 16;
  localparam int INDEX_W     = 24;
  localparam int OUT_SIZE_W  = 13;
  localparam int HDR_LEN     = 18;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  localparam logic [4:0] POS_TYPE     = 5'd2;
  localparam logic [4:0] POS_WIDTH_LO = 5'd12;
  localparam logic [4:0] POS_WIDTH_HI = 5'd13;
  localparam logic [4:0] POS_HEIGHT_LO = 5'd14;
  localparam logic [4:0] POS_HEIGHT_HI = 5'd15;
  localparam logic [4:0] POS_DEPTH    = 5'd16;
  localparam logic [4:0] POS_LAST     = 5'd17;

  localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
  localparam logic [7:0] TYPE_GREY      = 8'd3;
  localparam logic [2:0] BPP_RGB        = 3'd3;
  localparam logic [2:0] BPP_RGBA       = 3'd4;
  localparam logic [7:0] ALPHA_OPAQUE   = 8'd255;

  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_PIXEL     = 3'd1,
    KIND_BAD_TYPE  = 3'd2,
    KIND_BAD_DEPTH = 3'd3,
    KIND_BAD_SIZE  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXELS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_of_file;
  } tgd_in_t;

  typedef struct packed {
    logic [2:0]            kind;
    logic [INDEX_W-1:0]    pixel_index;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [7:0]            alpha;
    logic [OUT_SIZE_W-1:0] image_width;
    logic [OUT_SIZE_W-1:0] image_height;
    logic                  last_item;
  } tgd_out_t;

  typedef struct packed {
    kind_t                 kind;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [7:0]            alpha;
    logic [HDR_SIZE_W-1:0] width;
    logic [HDR_SIZE_W-1:0] height;
    logic                  last;
    logic                  end_of_row;
  } tgd_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tgd_qstat_t;

endpackage

FILE: rtl/tgd_front.sv
// tgd_front: byte parser; header fields, checks, pixel assembly, row/column tracking
// depends on tgd_pkg; pushes one command per result into the queue

module tgd_front #(
  parameter int MAX_SIDE = 4096,
  parameter int SIDE_W   = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_stall,
  input  tgd_pkg::tgd_in_t byte_data,
  input  tgd_pkg::tgd_qstat_t qstat,
  output logic             push,
  output tgd_pkg::tgd_cmd_t cmd
);

  tgd_pkg::phase_t phase, phase_next;
  logic [4:0]  hdr_pos, hdr_pos_next;
  logic [15:0] width_reg, width_reg_next;
  logic [15:0] height_reg, height_reg_next;
  logic [7:0]  depth_byte, depth_byte_next;
  logic [2:0]  bpp, bpp_next;
  logic [SIDE_W-1:0] col, col_next;
  logic [SIDE_W-1:0] row, row_next;
  logic [1:0]  byte_in_pixel, byte_in_pixel_next;
  logic [23:0] held, held_next;

  tgd_pkg::phase_t cur_phase;
  logic [4:0]  cur_pos;
  logic [15:0] cur_width;
  logic [15:0] cur_height;
  logic [7:0]  b;
  logic [4:0]  depth_div;
  logic        accept;
  logic        produce;
  logic        size_bad;
  logic [SIDE_W:0] col_inc;
  logic [SIDE_W:0] row_inc;

  assign accept     = byte_valid && !qstat.full;
  assign byte_stall = qstat.full;
  assign push       = accept && produce;
  assign b          = byte_data.byte_value;
  assign depth_div  = depth_byte[7:3];
  assign col_inc    = {1'b0, col} + {{SIDE_W{1'b0}}, 1'b1};
  assign row_inc    = {1'b0, row} + {{SIDE_W{1'b0}}, 1'b1};

  always_comb begin
    cur_phase  = byte_data.start_of_file ? tgd_pkg::PH_HEADER : phase;
    cur_pos    = byte_data.start_of_file ? 5'd0 : hdr_pos;
    cur_width  = byte_data.start_of_file ? 16'd0 : width_reg;
    cur_height = byte_data.start_of_file ? 16'd0 : height_reg;
    size_bad   = cur_width[15] || cur_height[15] ||
                 (cur_width > 16'(MAX_SIDE)) || (cur_height > 16'(MAX_SIDE));

    phase_next         = cur_phase;
    hdr_pos_next       = cur_pos;
    width_reg_next     = cur_width;
    height_reg_next    = cur_height;
    depth_byte_next    = byte_data.start_of_file ? 8'd0 : depth_byte;
    bpp_next           = byte_data.start_of_file ? 3'd0 : bpp;
    col_next           = byte_data.start_of_file ? '0 : col;
    row_next           = byte_data.start_of_file ? '0 : row;
    byte_in_pixel_next = byte_data.start_of_file ? 2'd0 : byte_in_pixel;
    held_next          = byte_data.start_of_file ? 24'd0 : held;

    produce        = 1'b0;
    cmd            = '0;
    cmd.kind       = tgd_pkg::KIND_HEADER;

    case (cur_phase)
      tgd_pkg::PH_HEADER: begin
        hdr_pos_next = cur_pos + 5'd1;
        case (cur_pos)
          tgd_pkg::POS_TYPE: begin
            if (b != tgd_pkg::TYPE_TRUECOLOR && b != tgd_pkg::TYPE_GREY) begin
              produce    = 1'b1;
              cmd.kind   = tgd_pkg::KIND_BAD_TYPE;
              cmd.last   = 1'b1;
              phase_next = tgd_pkg::PH_DONE;
            end
          end
          tgd_pkg::POS_WIDTH_LO:  width_reg_next  = {cur_width[15:8], b};
          tgd_pkg::POS_WIDTH_HI:  width_reg_next  = {b, cur_width[7:0]};
          tgd_pkg::POS_HEIGHT_LO: height_reg_next = {cur_height[15:8], b};
          tgd_pkg::POS_HEIGHT_HI: height_reg_next = {b, cur_height[7:0]};
          tgd_pkg::POS_DEPTH:     depth_byte_next = b;
          tgd_pkg::POS_LAST: begin
            produce  = 1'b1;
            cmd.last = 1'b1;
            if (depth_div != 5'(tgd_pkg::BPP_RGB) && depth_div != 5'(tgd_pkg::BPP_RGBA)) begin
              cmd.kind   = tgd_pkg::KIND_BAD_DEPTH;
              phase_next = tgd_pkg::PH_DONE;
            end else if (size_bad) begin
              cmd.kind   = tgd_pkg::KIND_BAD_SIZE;
              phase_next = tgd_pkg::PH_DONE;
            end else begin
              bpp_next           = depth_div[2:0];
              col_next           = '0;
              row_next           = '0;
              byte_in_pixel_next = 2'd0;
              held_next          = 24'd0;
              cmd.kind           = tgd_pkg::KIND_HEADER;
              cmd.width          = cur_width;
              cmd.height         = cur_height;
              if (cur_width == 16'd0 || cur_height == 16'd0) begin
                phase_next = tgd_pkg::PH_DONE;
              end else begin
                cmd.last   = 1'b0;
                phase_next = tgd_pkg::PH_PIXELS;
              end
            end
          end
          default: ;
        endcase
      end
      tgd_pkg::PH_PIXELS: begin
        if ({1'b0, byte_in_pixel} + 3'd1 < bpp) begin
          case (byte_in_pixel)
            2'd0:    held_next[7:0]   = b;
            2'd1:    held_next[15:8]  = b;
            default: held_next[23:16] = b;
          endcase
          byte_in_pixel_next = byte_in_pixel + 2'd1;
        end else begin
          produce   = 1'b1;
          cmd.kind  = tgd_pkg::KIND_PIXEL;
          cmd.blue  = held[7:0];
          cmd.green = held[15:8];
          if (bpp == tgd_pkg::BPP_RGBA) begin
            cmd.red   = held[23:16];
            cmd.alpha = b;
          end else begin
            cmd.red   = b;
            cmd.alpha = tgd_pkg::ALPHA_OPAQUE;
          end
          byte_in_pixel_next = 2'd0;
          held_next          = 24'd0;
          if (col_inc >= {1'b0, width_reg[SIDE_W-1:0]}) begin
            col_next       = '0;
            cmd.end_of_row = 1'b1;
            if (row_inc >= {1'b0, height_reg[SIDE_W-1:0]}) begin
              cmd.last   = 1'b1;
              phase_next = tgd_pkg::PH_DONE;
            end else begin
              row_next = row_inc[SIDE_W-1:0];
            end
          end else begin
            col_next = col_inc[SIDE_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= tgd_pkg::PH_HEADER;
      hdr_pos       <= 5'd0;
      width_reg     <= 16'd0;
      height_reg    <= 16'd0;
      depth_byte    <= 8'd0;
      bpp           <= 3'd0;
      col           <= '0;
      row           <= '0;
      byte_in_pixel <= 2'd0;
      held          <= 24'd0;
    end else if (accept) begin
      phase         <= phase_next;
      hdr_pos       <= hdr_pos_next;
      width_reg     <= width_reg_next;
      height_reg    <= height_reg_next;
      depth_byte    <= depth_byte_next;
      bpp           <= bpp_next;
      col           <= col_next;
      row           <= row_next;
      byte_in_pixel <= byte_in_pixel_next;
      held          <= held_next;
    end
  end

endmodule

FILE: rtl/tgd_queue.sv
// tgd_queue: short command queue between the parser and the output stage
// depends on tgd_pkg for the command type and depth constants

module tgd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tgd_pkg::tgd_cmd_t   push_cmd,
  input  logic                pop,
  output tgd_pkg::tgd_cmd_t   head,
  output tgd_pkg::tgd_qstat_t qstat
);

  tgd_pkg::tgd_cmd_t entries [tgd_pkg::QUEUE_DEPTH];
  logic [tgd_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [tgd_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [tgd_pkg::QUEUE_AW:0]   count;

  assign head        = entries[rd_ptr];
  assign qstat.full  = (count == (tgd_pkg::QUEUE_AW+1)'(tgd_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + (tgd_pkg::QUEUE_AW)'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + (tgd_pkg::QUEUE_AW)'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (tgd_pkg::QUEUE_AW+1)'(1);
        2'b01:   count <= count - (tgd_pkg::QUEUE_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/tgd_back.sv
// tgd_back: output stage; destination index from row base and column, result register
// depends on tgd_pkg; pops commands from tgd_queue

module tgd_back #(
  parameter int SIDE_W = 13
) (
  input  logic                clk,
  input  logic                rst,
  input  tgd_pkg::tgd_cmd_t   head,
  input  tgd_pkg::tgd_qstat_t qstat,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_stall,
  output tgd_pkg::tgd_out_t   result_data
);

  localparam int PROD_W = (2 * SIDE_W > tgd_pkg::INDEX_W) ? 2 * SIDE_W : tgd_pkg::INDEX_W;

  logic [tgd_pkg::INDEX_W-1:0] row_base;
  logic [SIDE_W-1:0]           col;
  logic [SIDE_W-1:0]           width_s;
  logic [SIDE_W-1:0]           h_s;
  logic [SIDE_W-1:0]           w_s;
  logic [PROD_W-1:0]           prod;

  assign pop  = !qstat.empty && (!result_valid || !result_stall);
  assign h_s  = head.height[SIDE_W-1:0];
  assign w_s  = head.width[SIDE_W-1:0];
  assign prod = PROD_W'(h_s - {{(SIDE_W-1){1'b0}}, 1'b1}) * PROD_W'(w_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_data.kind         <= head.kind;
      result_data.red          <= head.red;
      result_data.green        <= head.green;
      result_data.blue         <= head.blue;
      result_data.alpha        <= head.alpha;
      result_data.image_width  <= head.width[tgd_pkg::OUT_SIZE_W-1:0];
      result_data.image_height <= head.height[tgd_pkg::OUT_SIZE_W-1:0];
      result_data.last_item    <= head.last;
      result_data.pixel_index  <= (head.kind == tgd_pkg::KIND_PIXEL) ?
                                  row_base + tgd_pkg::INDEX_W'(col) : '0;
      if (head.kind == tgd_pkg::KIND_HEADER) begin
        row_base <= prod[tgd_pkg::INDEX_W-1:0];
        col      <= '0;
        width_s  <= w_s;
      end else if (head.kind == tgd_pkg::KIND_PIXEL) begin
        if (head.end_of_row) begin
          col      <= '0;
          row_base <= row_base - tgd_pkg::INDEX_W'(width_s);
        end else begin
          col <= col + SIDE_W'(1);
        end
      end
    end
  end

endmodule

FILE: rtl/tga_uncompressed_decoder.sv
// tga_uncompressed_decoder: top level; uncompressed 24/32-bit tga byte stream to rgba pixels
// a byte's command is queued on acceptance, then registered as a result when not stalled
// throughput: one byte per cycle while the queue is not full (single-byte parser update)
// a four-entry command queue lets parser and output stage stall independently
// reset: synchronous, clears parser state, queue pointers and result valid; no clearing pass
// depends on tgd_pkg, tgd_front, tgd_queue, tgd_back

module tga_uncompressed_decoder #(
  parameter int MAX_SIDE = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  tgd_pkg::tgd_in_t  byte_data,
  output logic              result_valid,
  input  logic              result_stall,
  output tgd_pkg::tgd_out_t result_data
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);

  logic                push;
  logic                pop;
  tgd_pkg::tgd_cmd_t   push_cmd;
  tgd_pkg::tgd_cmd_t   head;
  tgd_pkg::tgd_qstat_t qstat;

  tgd_front #(
    .MAX_SIDE (MAX_SIDE),
    .SIDE_W   (SIDE_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .qstat      (qstat),
    .push       (push),
    .cmd        (push_cmd)
  );

  tgd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  tgd_back #(
    .SIDE_W (SIDE_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .qstat        (qstat),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule

FILE: sim/tb_top.sv
// tb_top: self-checking bench for tga_uncompressed_decoder, fed with tga byte streams
// beats are predicted on acceptance and compared field by field; random idling on both sides
// depends on tgd_pkg and the rtl of tga_uncompressed_decoder
`timescale 1ns / 100ps

module tb_top;

  localparam int MAX_SIDE = 4096;
  localparam int CALM_FROM = 800;
  localparam int CALM_TO = 1600;
  localparam int RANDOM_BYTES = 950;

  typedef struct {
    tgd_pkg::tgd_in_t beat;
    bit               drain;
  } stream_entry_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              byte_valid = 1'b0;
  logic              byte_stall;
  tgd_pkg::tgd_in_t  byte_data = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  tgd_pkg::tgd_out_t result_data;

  stream_entry_t     file_bytes_q[$];
  tgd_pkg::tgd_out_t decoded_q[$];
  stream_entry_t     next_entry;
  int            cyc = 0;
  int            errors = 0;
  int            bytes_taken = 0;
  int            hdr_count = 0;
  int            pix_count = 0;
  int            reject_count = 0;
  int            pushed = 0;

  // decoder state mirror
  tgd_pkg::phase_t parse_phase;
  logic [4:0]  hdr_pos;
  logic [15:0] wreg;
  logic [15:0] hreg;
  logic [7:0]  depth_reg;
  logic [2:0]  bpp;
  logic [12:0] col;
  logic [12:0] row;
  logic [23:0] rbase;
  logic [1:0]  bip;
  logic [23:0] held;

  tga_uncompressed_decoder #(.MAX_SIDE(MAX_SIDE)) uut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_data(byte_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_data(result_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cyc <= cyc + 1;

  function automatic bit take_break();
    return (cyc < CALM_FROM || cyc >= CALM_TO) && $urandom_range(99) < 34;
  endfunction

  task automatic parser_restart();
    parse_phase = tgd_pkg::PH_HEADER;
    hdr_pos = '0;
    wreg = '0;
    hreg = '0;
    depth_reg = '0;
    bpp = '0;
    col = '0;
    row = '0;
    rbase = '0;
    bip = '0;
    held = '0;
  endtask

  task automatic reject_file(inout tgd_pkg::tgd_out_t res, input tgd_pkg::kind_t why);
    res.kind = why;
    res.last_item = 1'b1;
    parse_phase = tgd_pkg::PH_DONE;
    reject_count++;
  endtask

  task automatic decode_byte(input tgd_pkg::tgd_in_t beat);
    tgd_pkg::tgd_out_t res;
    bit         emit;
    logic [4:0] pos;
    logic [4:0] per;
    logic [7:0] b;
    res = '0;
    emit = 1'b0;
    b = beat.byte_value;
    if (beat.start_of_file) parser_restart();
    case (parse_phase)
      tgd_pkg::PH_HEADER: begin
        pos = hdr_pos;
        hdr_pos = pos + 5'd1;
        case (pos)
          tgd_pkg::POS_TYPE: begin
            if (b != tgd_pkg::TYPE_TRUECOLOR && b != tgd_pkg::TYPE_GREY) begin
              reject_file(res, tgd_pkg::KIND_BAD_TYPE);
              emit = 1'b1;
            end
          end
          tgd_pkg::POS_WIDTH_LO:  wreg[7:0] = b;
          tgd_pkg::POS_WIDTH_HI:  wreg[15:8] = b;
          tgd_pkg::POS_HEIGHT_LO: hreg[7:0] = b;
          tgd_pkg::POS_HEIGHT_HI: hreg[15:8] = b;
          tgd_pkg::POS_DEPTH:     depth_reg = b;
          tgd_pkg::POS_LAST: begin
            emit = 1'b1;
            per = depth_reg[7:3];
            if (per != 5'(tgd_pkg::BPP_RGB) && per != 5'(tgd_pkg::BPP_RGBA)) begin
              reject_file(res, tgd_pkg::KIND_BAD_DEPTH);
            end else if (wreg[15] || hreg[15] || wreg > MAX_SIDE || hreg > MAX_SIDE) begin
              reject_file(res, tgd_pkg::KIND_BAD_SIZE);
            end else begin
              bpp = per[2:0];
              col = '0;
              row = '0;
              bip = '0;
              held = '0;
              res.kind = tgd_pkg::KIND_HEADER;
              res.image_width = wreg[12:0];
              res.image_height = hreg[12:0];
              hdr_count++;
              if (wreg == 0 || hreg == 0) begin
                res.last_item = 1'b1;
                parse_phase = tgd_pkg::PH_DONE;
              end else begin
                rbase = 24'((32'(hreg) - 1) * 32'(wreg));
                parse_phase = tgd_pkg::PH_PIXELS;
              end
            end
          end
          default: ;
        endcase
      end
      tgd_pkg::PH_PIXELS: begin
        if (32'(bip) + 1 < 32'(bpp)) begin
          held = held | (24'(b) << (8 * bip));
          bip = bip + 2'd1;
        end else begin
          emit = 1'b1;
          pix_count++;
          res.kind = tgd_pkg::KIND_PIXEL;
          res.pixel_index = rbase + 24'(col);
          res.blue = held[7:0];
          res.green = held[15:8];
          if (bpp == tgd_pkg::BPP_RGBA) begin
            res.red = held[23:16];
            res.alpha = b;
          end else begin
            res.red = b;
            res.alpha = tgd_pkg::ALPHA_OPAQUE;
          end
          bip = '0;
          held = '0;
          if (32'(col) + 1 >= 32'(wreg)) begin
            col = '0;
            if (32'(row) + 1 >= 32'(hreg)) begin
              res.last_item = 1'b1;
              parse_phase = tgd_pkg::PH_DONE;
            end else begin
              row = row + 13'd1;
              rbase = rbase - 24'(wreg);
            end
          end else begin
            col = col + 13'd1;
          end
        end
      end
      default: ;
    endcase
    if (emit) decoded_q.push_back(res);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic compare_result(input tgd_pkg::tgd_out_t want, input tgd_pkg::tgd_out_t got);
    check_field("kind", want.kind, got.kind);
    check_field("pixel_index", want.pixel_index, got.pixel_index);
    check_field("red", want.red, got.red);
    check_field("green", want.green, got.green);
    check_field("blue", want.blue, got.blue);
    check_field("alpha", want.alpha, got.alpha);
    check_field("image_width", want.image_width, got.image_width);
    check_field("image_height", want.image_height, got.image_height);
    check_field("last_item", want.last_item, got.last_item);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      parser_restart();
    end else begin
      if (byte_valid && !byte_stall) begin
        decode_byte(byte_data);
        bytes_taken++;
      end
      if (!byte_valid || !byte_stall) begin
        if (file_bytes_q.size() != 0 && file_bytes_q[0].drain) begin
          byte_valid <= 1'b0;
          if (decoded_q.size() == 0) void'(file_bytes_q.pop_front());
        end else if (file_bytes_q.size() != 0 && !take_break()) begin
          next_entry = file_bytes_q.pop_front();
          byte_valid <= 1'b1;
          byte_data <= next_entry.beat;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result beat, kind %0d", result_data.kind);
          errors++;
        end else begin
          compare_result(decoded_q.pop_front(), result_data);
        end
      end
      result_stall <= take_break();
    end
  end

  task automatic push_beat(input logic [7:0] b, input bit sof);
    stream_entry_t e;
    e.beat.byte_value = b;
    e.beat.start_of_file = sof;
    e.drain = 1'b0;
    file_bytes_q.push_back(e);
    pushed++;
  endtask

  task automatic push_drain();
    stream_entry_t e;
    e.beat = '0;
    e.drain = 1'b1;
    file_bytes_q.push_back(e);
  endtask

  function automatic int pixel_bytes(input int w, input int h, input logic [7:0] depth);
    return w * h * int'(depth[7:3]);
  endfunction

  task automatic add_file(input logic [7:0] ftype, input logic [15:0] w, input logic [15:0] h,
                          input logic [7:0] depth, input int body, input bit flagged);
    logic [7:0] b;
    for (int i = 0; i < tgd_pkg::HDR_LEN; i++) begin
      b = 8'($urandom);
      case (5'(i))
        tgd_pkg::POS_TYPE:      b = ftype;
        tgd_pkg::POS_WIDTH_LO:  b = w[7:0];
        tgd_pkg::POS_WIDTH_HI:  b = w[15:8];
        tgd_pkg::POS_HEIGHT_LO: b = h[7:0];
        tgd_pkg::POS_HEIGHT_HI: b = h[15:8];
        tgd_pkg::POS_DEPTH:     b = depth;
        default: ;
      endcase
      push_beat(b, flagged && i == 0);
    end
    for (int i = 0; i < body; i++) push_beat(8'($urandom), 1'b0);
  endtask

  task automatic add_random_file();
    logic [7:0]  t;
    logic [7:0]  d;
    logic [15:0] w;
    logic [15:0] h;
    int          full;
    int          r;
    r = $urandom_range(99);
    t = $urandom_range(1) ? tgd_pkg::TYPE_TRUECOLOR : tgd_pkg::TYPE_GREY;
    case ($urandom_range(3))
      0: d = 8'd24;
      1: d = 8'd32;
      default: d = 8'($urandom_range(24, 39));
    endcase
    w = 16'($urandom_range(1, 6));
    h = 16'($urandom_range(1, 6));
    if (r < 70) begin
      if ($urandom_range(19) == 0) begin
        if ($urandom_range(1)) w = '0;
        else h = '0;
      end
      full = pixel_bytes(w, h, d);
      if ($urandom_range(9) == 0) add_file(t, w, h, d, $urandom_range(0, full), 1'b1);
      else add_file(t, w, h, d, full + $urandom_range(0, 3), 1'b1);
    end else if (r < 73) begin
      w = 16'($urandom_range(1000, MAX_SIDE));
      h = 16'($urandom_range(1000, MAX_SIDE));
      add_file(t, w, h, d, $urandom_range(3, 30), 1'b1);
    end else if (r < 81) begin
      do t = 8'($urandom); while (t == tgd_pkg::TYPE_TRUECOLOR || t == tgd_pkg::TYPE_GREY);
      add_file(t, w, h, d, $urandom_range(0, 3), 1'b1);
    end else if (r < 88) begin
      do d = 8'($urandom);
      while (d[7:3] == 5'(tgd_pkg::BPP_RGB) || d[7:3] == 5'(tgd_pkg::BPP_RGBA));
      add_file(t, w, h, d, $urandom_range(0, 3), 1'b1);
    end else if (r < 95) begin
      if ($urandom_range(1)) w = 16'($urandom_range(MAX_SIDE + 1, 65535));
      else h = 16'($urandom_range(MAX_SIDE + 1, 65535));
      add_file(t, w, h, d, $urandom_range(0, 3), 1'b1);
    end else begin
      repeat ($urandom_range(1, 12)) push_beat(8'($urandom), $urandom_range(3) == 0);
    end
  endtask

  initial begin
    int directed;
    int last_drain;
    // no start flag right after reset, then trailing bytes
    add_file(tgd_pkg::TYPE_TRUECOLOR, 16'd2, 16'd2, 8'd24, 12 + 2, 1'b0);
    add_file(tgd_pkg::TYPE_GREY, 16'd3, 16'd1, 8'd32, 12, 1'b1);
    add_file(tgd_pkg::TYPE_GREY, 16'd1, 16'd2, 8'd31, 6, 1'b1);
    add_file(tgd_pkg::TYPE_TRUECOLOR, 16'd2, 16'd1, 8'd39, 8, 1'b1);
    add_file(8'd0, 16'd1, 16'd1, 8'd24, 3, 1'b1);
    add_file(8'd255, 16'd1, 16'd1, 8'd24, 0, 1'b1);
    add_file(8'd10, 16'd1, 16'd1, 8'd24, 0, 1'b1);
    add_file(tgd_pkg::TYPE_TRUECOLOR, 16'd1, 16'd1, 8'd16, 3, 1'b1);
    add_file(tgd_pkg::TYPE_TRUECOLOR, 16'd1, 16'd1, 8'd0, 0, 1'b1);
    add_file(tgd_pkg::TYPE_TRUECOLOR, 16'd1, 16'd1, 8'd255, 0, 1'b1);
    add_file(tgd_pkg::TYPE_TRUECOLOR, 16'd1, 16'd1, 8'd40, 0, 1'b1);
    add_file(tgd_pkg::TYPE_TRUECOLOR, 16'h8000, 16'd1, 8'd24, 3, 1'b1);
    add_file(tgd_pkg::TYPE_TRUECOLOR, 16'd1, 16'hFFFF, 8'd24, 0, 1'b1);
    add_file(tgd_pkg::TYPE_TRUECOLOR, 16'd4097, 16'd1, 8'd32, 0, 1'b1);
    add_file(tgd_pkg::TYPE_GREY, 16'd1, 16'd4097, 8'd32, 0, 1'b1);
    add_file(tgd_pkg::TYPE_TRUECOLOR, 16'd0, 16'd5, 8'd24, 4, 1'b1);
    add_file(tgd_pkg::TYPE_TRUECOLOR, 16'd4096, 16'd0, 8'd32, 0, 1'b1);
    // widest image, only a few pixels before restarting
    add_file(tgd_pkg::TYPE_TRUECOLOR, 16'd4096, 16'd4096, 8'd32, 12, 1'b1);
    add_file(tgd_pkg::TYPE_GREY, 16'd1, 16'd4096, 8'd24, 9, 1'b1);
    // restart in the middle of a header
    for (int i = 0; i < 7; i++) push_beat(8'($urandom), i == 0);
    add_file(tgd_pkg::TYPE_TRUECOLOR, 16'd1, 16'd1, 8'd24, 3, 1'b1);
    push_drain();
    directed = pushed;
    last_drain = pushed;
    while (pushed - directed < RANDOM_BYTES) begin
      add_random_file();
      if (pushed - last_drain > 300) begin
        push_drain();
        last_drain = pushed;
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (file_bytes_q.size() != 0 || byte_valid) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("streamed %0d bytes: %0d headers accepted, %0d pixels, %0d files rejected",
             bytes_taken, hdr_count, pix_count, reject_count);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", decoded_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: tga_uncompressed_decoder.f
rtl/tgd_pkg.sv
rtl/tgd_front.sv
rtl/tgd_queue.sv
rtl/tgd_back.sv
rtl/tga_uncompressed_decoder.sv
sim/tb_top.sv
